// File: hdl/websocket_frame_decoder_assert.svh
// Assertion macros used by the frame decoder's top-level RTL file.
`ifndef WEBSOCKET_FRAME_DECODER_ASSERT_SVH
`define WEBSOCKET_FRAME_DECODER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define WSFD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("frame decoder assertion failed");

// Next-cycle implication, checked outside reset.
`define WSFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("frame decoder assertion failed");

`endif

// File: hdl/wsfd_pkg.sv
// Types and constants of the WebSocket frame decoder.
package wsfd_pkg;

    // Parser phases, one-hot.
    typedef enum logic [5:0] {
        PH_HDR0    = 6'b000001,
        PH_HDR1    = 6'b000010,
        PH_EXT16   = 6'b000100,
        PH_EXT64   = 6'b001000,
        PH_KEY     = 6'b010000,
        PH_PAYLOAD = 6'b100000
    } t_phase;

    // Result kinds.
    localparam logic [1:0] KIND_DATA     = 2'd0;
    localparam logic [1:0] KIND_EMPTY    = 2'd1;
    localparam logic [1:0] KIND_NONFINAL = 2'd2;
    localparam logic [1:0] KIND_TOOLONG  = 2'd3;

    // Seven-bit length codes that announce an extended length.
    localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
    localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

    // Header byte counts at which a phase is complete. The 64-bit length
    // takes eight bytes, so its three-bit count wraps to zero.
    localparam logic [2:0] EXT16_DONE_CNT = 3'd2;
    localparam logic [2:0] EXT64_DONE_CNT = 3'd0;
    localparam logic [2:0] KEY_DONE_CNT   = 3'd4;

    localparam logic [31:0] MAX_LEN_RESET = 32'd1048576;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] payload_byte;
        logic [3:0] frame_opcode;
        logic       last_byte;
    } t_result;

endpackage

// File: hdl/websocket_frame_decoder.sv
// WebSocket frame decoder: takes one received stream byte per request and
// returns at most one result per byte. The header (FIN and opcode, mask bit
// and seven-bit length, optional 16-bit or 64-bit big-endian length, optional
// four-byte masking key) is parsed byte by byte, and payload bytes are
// unmasked on the fly and returned with the final one flagged. A zero-length
// frame returns one completion result; a non-final frame returns an error on
// its second header byte, and a length above max_payload_length, or above what
// LENGTH_COUNTER_BITS can count, returns an error when the length is complete.
// After any error or completed frame the next byte is a new first header byte.
// Throughput is one byte per clock cycle while o_in_stall is low: each byte
// updates the parser state in the cycle it is taken, and its result is
// registered in the output register, or in the skid register when the output
// register is full and stalled. The skid register absorbs one result when the
// output side stalls; o_in_stall rises only while that skid register is
// full. max_payload_length is written through i_max_payload_length_we and
// resets to 1048576; write it only while no frame is in progress.
`include "websocket_frame_decoder_assert.svh"

module websocket_frame_decoder #(
    parameter int LENGTH_COUNTER_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration register.
    input  logic        i_max_payload_length_we,
    input  logic [31:0] i_max_payload_length,
    // Byte stream in.
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_stream_byte,
    // Results out.
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_payload_byte,
    output logic [3:0]  o_frame_opcode,
    output logic        o_last_byte
);

    logic [31:0]       r_max_len;
    logic              r_out_valid;
    wsfd_pkg::t_result r_out;
    logic              r_skid_valid;
    wsfd_pkg::t_result r_skid;

    logic              in_accept;
    logic              out_take;
    logic              res_valid;
    wsfd_pkg::t_result res;

    // The input side stalls only while the skid register holds a result.
    assign o_in_stall = r_skid_valid;
    assign in_accept  = i_in_valid && !r_skid_valid;
    assign out_take   = r_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= wsfd_pkg::MAX_LEN_RESET;
        end else if (i_max_payload_length_we) begin
            r_max_len <= i_max_payload_length;
        end
    end

    wsfd_parser #(
        .LENGTH_COUNTER_BITS(LENGTH_COUNTER_BITS)
    ) u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (in_accept),
        .i_byte     (i_stream_byte),
        .i_max_len  (r_max_len),
        .o_res_valid(res_valid),
        .o_res      (res)
    );

    // Output register with a one-entry skid register behind it. When the
    // skid register is full no new byte is taken, so a new result can only
    // arrive while the skid register is empty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (res_valid) begin
            if (!r_out_valid || out_take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out <= r_skid;
            end
        end else if (res_valid) begin
            if (!r_out_valid || out_take) begin
                r_out <= res;
            end else begin
                r_skid <= res;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_out.kind;
    assign o_payload_byte = r_out.payload_byte;
    assign o_frame_opcode = r_out.frame_opcode;
    assign o_last_byte    = r_out.last_byte;

    // The skid register is only ever filled behind a full output register.
    `WSFD_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)

    // A full skid register is not drained without the output side taking.
    `WSFD_ASSERT_NEXT(a_skid_holds, i_clk, i_rst_n, r_skid_valid && !out_take, r_skid_valid)

    // Error results carry neither payload data nor the last flag.
    `WSFD_ASSERT_NOW(a_error_clean, i_clk, i_rst_n, r_out_valid && (r_out.kind == wsfd_pkg::KIND_NONFINAL || r_out.kind == wsfd_pkg::KIND_TOOLONG), r_out.payload_byte == 8'd0 && !r_out.last_byte)

endmodule

// File: hdl/wsfd_parser.sv
// Frame header parser and payload unmasker; handles one byte per cycle while i_accept is high.
module wsfd_parser #(
    parameter int LENGTH_COUNTER_BITS = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_byte,
    input  logic [31:0]      i_max_len,
    output logic             o_res_valid,
    output wsfd_pkg::t_result o_res
);

    localparam int LCB = LENGTH_COUNTER_BITS;

    wsfd_pkg::t_phase r_phase, n_phase;
    logic [2:0]       r_cnt, n_cnt;
    logic [63:0]      r_len, n_len;
    logic [LCB-1:0]   r_rem, n_rem;
    logic [31:0]      r_key, n_key;
    logic [1:0]       r_kidx, n_kidx;
    logic [3:0]       r_opcode, n_opcode;
    logic             r_masked, n_masked;
    logic             r_final, n_final;

    logic [63:0] len_new;
    logic [2:0]  cnt_inc;
    logic        cnt_over;
    logic        too_long;
    logic        len_zero;
    logic        rem_last;
    logic [7:0]  key_byte;
    logic        do_len_done;
    logic        do_start;

    // Length as it stands after this byte.
    always_comb begin
        case (r_phase)
            wsfd_pkg::PH_HDR1:  len_new = {57'd0, i_byte[6:0]};
            wsfd_pkg::PH_EXT16,
            wsfd_pkg::PH_EXT64: len_new = {r_len[55:0], i_byte};
            default:            len_new = r_len;
        endcase
    end

    generate
        if (LCB < 64) begin : g_cnt_over
            assign cnt_over = |len_new[63:LCB];
        end else begin : g_no_cnt_over
            assign cnt_over = 1'b0;
        end
    endgenerate

    assign too_long = (|len_new[63:32]) || (len_new[31:0] > i_max_len) || cnt_over;
    assign len_zero = (len_new == 64'd0);
    assign cnt_inc  = r_cnt + 3'd1;
    assign rem_last = (r_rem[LCB-1:1] == '0);
    assign key_byte = r_masked ? r_key[{~r_kidx, 3'b000} +: 8] : 8'd0;

    always_comb begin
        n_phase     = r_phase;
        n_cnt       = r_cnt;
        n_len       = r_len;
        n_rem       = r_rem;
        n_key       = r_key;
        n_kidx      = r_kidx;
        n_opcode    = r_opcode;
        n_masked    = r_masked;
        n_final     = r_final;
        do_len_done = 1'b0;
        do_start    = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '{kind: wsfd_pkg::KIND_DATA, payload_byte: 8'd0,
                        frame_opcode: r_opcode, last_byte: 1'b0};

        if (i_accept) begin
            case (r_phase)
                wsfd_pkg::PH_HDR1: begin
                    n_masked = i_byte[7];
                    n_cnt    = 3'd0;
                    n_len    = 64'd0;
                    if (!r_final) begin
                        n_phase          = wsfd_pkg::PH_HDR0;
                        o_res_valid      = 1'b1;
                        o_res.kind       = wsfd_pkg::KIND_NONFINAL;
                    end else if (i_byte[6:0] == wsfd_pkg::LEN_CODE_EXT16) begin
                        n_phase = wsfd_pkg::PH_EXT16;
                    end else if (i_byte[6:0] == wsfd_pkg::LEN_CODE_EXT64) begin
                        n_phase = wsfd_pkg::PH_EXT64;
                    end else begin
                        n_len       = len_new;
                        do_len_done = 1'b1;
                    end
                end
                wsfd_pkg::PH_EXT16, wsfd_pkg::PH_EXT64: begin
                    n_len = len_new;
                    n_cnt = cnt_inc;
                    if (cnt_inc == ((r_phase == wsfd_pkg::PH_EXT16) ?
                                    wsfd_pkg::EXT16_DONE_CNT : wsfd_pkg::EXT64_DONE_CNT)) begin
                        do_len_done = 1'b1;
                    end
                end
                wsfd_pkg::PH_KEY: begin
                    n_key = {r_key[23:0], i_byte};
                    n_cnt = cnt_inc;
                    if (cnt_inc == wsfd_pkg::KEY_DONE_CNT) begin
                        do_start = 1'b1;
                    end
                end
                wsfd_pkg::PH_PAYLOAD: begin
                    n_kidx             = r_kidx + 2'd1;
                    o_res_valid        = 1'b1;
                    o_res.payload_byte = i_byte ^ key_byte;
                    o_res.last_byte    = rem_last;
                    if (rem_last) begin
                        n_rem   = '0;
                        n_phase = wsfd_pkg::PH_HDR0;
                    end else begin
                        n_rem = r_rem - {{(LCB-1){1'b0}}, 1'b1};
                    end
                end
                default: begin
                    // First header byte: FIN and opcode.
                    n_final  = i_byte[7];
                    n_opcode = i_byte[3:0];
                    n_cnt    = 3'd0;
                    n_phase  = wsfd_pkg::PH_HDR1;
                end
            endcase

            if (do_len_done) begin
                n_cnt = 3'd0;
                if (too_long) begin
                    n_phase     = wsfd_pkg::PH_HDR0;
                    o_res_valid = 1'b1;
                    o_res.kind  = wsfd_pkg::KIND_TOOLONG;
                end else if (n_masked) begin
                    n_key   = 32'd0;
                    n_phase = wsfd_pkg::PH_KEY;
                end else begin
                    do_start = 1'b1;
                end
            end

            if (do_start) begin
                n_kidx = 2'd0;
                n_cnt  = 3'd0;
                if (len_zero) begin
                    n_phase         = wsfd_pkg::PH_HDR0;
                    o_res_valid     = 1'b1;
                    o_res.kind      = wsfd_pkg::KIND_EMPTY;
                    o_res.last_byte = 1'b1;
                end else begin
                    n_rem   = len_new[LCB-1:0];
                    n_phase = wsfd_pkg::PH_PAYLOAD;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= wsfd_pkg::PH_HDR0;
            r_cnt    <= 3'd0;
            r_len    <= 64'd0;
            r_rem    <= '0;
            r_key    <= 32'd0;
            r_kidx   <= 2'd0;
            r_opcode <= 4'd0;
            r_masked <= 1'b0;
            r_final  <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_cnt    <= n_cnt;
            r_len    <= n_len;
            r_rem    <= n_rem;
            r_key    <= n_key;
            r_kidx   <= n_kidx;
            r_opcode <= n_opcode;
            r_masked <= n_masked;
            r_final  <= n_final;
        end
    end

endmodule

// File: test/websocket_frame_decoder_checker.sv
// Result checker for the WebSocket frame decoder: predicts results and compares.
module websocket_frame_decoder_checker #(
    parameter int LENGTH_COUNTER_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_max_payload_length_we,
    input  logic [31:0] i_max_payload_length,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_stream_byte,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_payload_byte,
    input  logic [3:0]  i_frame_opcode,
    input  logic        i_last_byte,
    output int          o_mismatches,
    output int          o_pending,
    output int          o_data_results,
    output int          o_empty_results,
    output int          o_nonfinal_results,
    output int          o_toolong_results
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 30;
    localparam logic [63:0] COUNTER_MAX = (LENGTH_COUNTER_BITS >= 64) ? {64{1'b1}} :
                                          ((64'd1 << LENGTH_COUNTER_BITS) - 64'd1);

    // Parser state as the decoder should hold it.
    wsfd_pkg::t_phase               phase;
    logic [2:0]                     hdr_count;
    logic [63:0]                    len_acc;
    logic [LENGTH_COUNTER_BITS-1:0] remaining;
    logic [31:0]                    key;
    logic [1:0]                     key_sel;
    logic [3:0]                     opcode;
    logic                           masked;
    logic                           fin;
    logic [31:0]                    max_len;

    wsfd_pkg::t_result due_results[$];

    task automatic report_mismatch(input string what);
        // Only the first few are printed; all of them are counted.
        if (o_mismatches < REPORT_LIMIT) begin
            $display("[%0t] frame check: %s", $realtime, what);
        end
        o_mismatches++;
    endtask

    function automatic wsfd_pkg::t_result make_result(input logic [1:0] kind,
                                                      input logic [7:0] data,
                                                      input logic last);
        wsfd_pkg::t_result r;
        r.kind         = kind;
        r.payload_byte = data;
        r.frame_opcode = opcode;
        r.last_byte    = last;
        return r;
    endfunction

    // The header is complete: a zero length finishes the frame here.
    function automatic bit open_payload(output wsfd_pkg::t_result r);
        r         = '0;
        key_sel   = '0;
        hdr_count = '0;
        if (len_acc == 64'd0) begin
            phase = wsfd_pkg::PH_HDR0;
            r     = make_result(wsfd_pkg::KIND_EMPTY, 8'h00, 1'b1);
            return 1'b1;
        end
        remaining = len_acc[LENGTH_COUNTER_BITS-1:0];
        phase     = wsfd_pkg::PH_PAYLOAD;
        return 1'b0;
    endfunction

    // The length is complete: check it, then go on to the key or the payload.
    function automatic bit close_length(output wsfd_pkg::t_result r);
        r         = '0;
        hdr_count = '0;
        if (len_acc > {32'd0, max_len} || len_acc > COUNTER_MAX) begin
            phase = wsfd_pkg::PH_HDR0;
            r     = make_result(wsfd_pkg::KIND_TOOLONG, 8'h00, 1'b0);
            return 1'b1;
        end
        if (masked) begin
            key   = '0;
            phase = wsfd_pkg::PH_KEY;
            return 1'b0;
        end
        return open_payload(r);
    endfunction

    function automatic bit parse_byte(input logic [7:0] b, output wsfd_pkg::t_result r);
        logic [7:0] key_byte;
        logic [2:0] done_cnt;
        r = '0;
        case (phase)
            wsfd_pkg::PH_HDR1: begin
                masked    = b[7];
                hdr_count = '0;
                len_acc   = '0;
                if (!fin) begin
                    phase = wsfd_pkg::PH_HDR0;
                    r     = make_result(wsfd_pkg::KIND_NONFINAL, 8'h00, 1'b0);
                    return 1'b1;
                end
                if (b[6:0] == wsfd_pkg::LEN_CODE_EXT16) begin
                    phase = wsfd_pkg::PH_EXT16;
                    return 1'b0;
                end
                if (b[6:0] == wsfd_pkg::LEN_CODE_EXT64) begin
                    phase = wsfd_pkg::PH_EXT64;
                    return 1'b0;
                end
                len_acc = {57'd0, b[6:0]};
                return close_length(r);
            end
            wsfd_pkg::PH_EXT16, wsfd_pkg::PH_EXT64: begin
                len_acc   = {len_acc[55:0], b};
                hdr_count = hdr_count + 3'd1;
                done_cnt  = (phase == wsfd_pkg::PH_EXT16) ? wsfd_pkg::EXT16_DONE_CNT :
                                                            wsfd_pkg::EXT64_DONE_CNT;
                if (hdr_count == done_cnt) begin
                    return close_length(r);
                end
                return 1'b0;
            end
            wsfd_pkg::PH_KEY: begin
                key       = {key[23:0], b};
                hdr_count = hdr_count + 3'd1;
                if (hdr_count == wsfd_pkg::KEY_DONE_CNT) begin
                    return open_payload(r);
                end
                return 1'b0;
            end
            wsfd_pkg::PH_PAYLOAD: begin
                key_byte = masked ? key[8 * (3 - key_sel) +: 8] : 8'h00;
                key_sel  = key_sel + 2'd1;
                r        = make_result(wsfd_pkg::KIND_DATA, b ^ key_byte, remaining <= 1);
                if (remaining <= 1) begin
                    remaining = '0;
                    phase     = wsfd_pkg::PH_HDR0;
                end else begin
                    remaining = remaining - 1'b1;
                end
                return 1'b1;
            end
            default: begin
                fin       = b[7];
                opcode    = b[3:0];
                hdr_count = '0;
                phase     = wsfd_pkg::PH_HDR1;
                return 1'b0;
            end
        endcase
    endfunction

    always @(posedge i_clk) begin : watch
        wsfd_pkg::t_result got;
        wsfd_pkg::t_result want;
        wsfd_pkg::t_result predicted;
        if (!i_rst_n) begin
            phase     = wsfd_pkg::PH_HDR0;
            hdr_count = '0;
            len_acc   = '0;
            remaining = '0;
            key       = '0;
            key_sel   = '0;
            opcode    = '0;
            masked    = 1'b0;
            fin       = 1'b0;
            max_len   = wsfd_pkg::MAX_LEN_RESET;
            due_results.delete();
        end else begin
            // Results leaving now stem from older requests, so they are compared first.
            if (i_out_valid && !i_out_stall) begin
                got.kind         = i_kind;
                got.payload_byte = i_payload_byte;
                got.frame_opcode = i_frame_opcode;
                got.last_byte    = i_last_byte;
                if (due_results.size() == 0) begin
                    report_mismatch($sformatf("result with none due: kind %0d byte %02h",
                                              got.kind, got.payload_byte));
                end else begin
                    want = due_results.pop_front();
                    case (want.kind)
                        wsfd_pkg::KIND_DATA:     o_data_results++;
                        wsfd_pkg::KIND_EMPTY:    o_empty_results++;
                        wsfd_pkg::KIND_NONFINAL: o_nonfinal_results++;
                        default:                 o_toolong_results++;
                    endcase
                    if (got.kind != want.kind) begin
                        report_mismatch($sformatf("kind %0d, expected %0d",
                                                  got.kind, want.kind));
                    end
                    if (got.payload_byte != want.payload_byte) begin
                        report_mismatch($sformatf("payload byte %02h, expected %02h",
                                                  got.payload_byte, want.payload_byte));
                    end
                    if (got.frame_opcode != want.frame_opcode) begin
                        report_mismatch($sformatf("opcode %0h, expected %0h",
                                                  got.frame_opcode, want.frame_opcode));
                    end
                    if (got.last_byte != want.last_byte) begin
                        report_mismatch($sformatf("last flag %0b, expected %0b",
                                                  got.last_byte, want.last_byte));
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (parse_byte(i_stream_byte, predicted)) begin
                    due_results.push_back(predicted);
                end
            end
            if (i_max_payload_length_we) begin
                max_len = i_max_payload_length;
            end
        end
        o_pending = due_results.size();
    end

endmodule

// File: test/websocket_frame_decoder_tb.sv
// Testbench top for the WebSocket frame decoder: stimulus, flow control and verdict.
module websocket_frame_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          LENGTH_COUNTER_BITS = 32;
    localparam int          HALF_PERIOD         = 4;
    localparam int          RESET_CYCLES        = 10;
    // Results pass through the output register, and also the skid register when the output stalls.
    localparam int          SETTLE_CYCLES       = 6;
    localparam int          HOLD_CYCLES         = 200;
    localparam int unsigned CYCLE_LIMIT         = 500000;

    // Idling intensity shared by the sender and the receiver.
    localparam int unsigned IDLE_NONE  = 0;
    localparam int unsigned IDLE_LIGHT = 1;
    localparam int unsigned IDLE_HEAVY = 2;

    // Directed opening: an empty control frame finished on its second header byte,
    // a non-final frame, a masked one-byte frame whose key starts with all ones,
    // a masked empty frame with a 16-bit length and the reserved bits set (it ends
    // on the last key byte), and a masked frame whose 64-bit length is all ones,
    // which must be refused without taking any key bytes.
    localparam logic [7:0] DIRECTED_STREAM [29] = '{
        8'h89, 8'h00,
        8'h01, 8'h85,
        8'h82, 8'h81, 8'hFF, 8'h00, 8'hA5, 8'h5A, 8'hFF,
        8'hF0, 8'hFE, 8'h00, 8'h00, 8'h12, 8'h34, 8'h56, 8'h78,
        8'h8A, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_max_payload_length_we;
    logic [31:0] i_max_payload_length;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_stream_byte;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [1:0]  o_kind;
    logic [7:0]  o_payload_byte;
    logic [3:0]  o_frame_opcode;
    logic        o_last_byte;

    int          mismatches;
    int          pending;
    int          data_results;
    int          empty_results;
    int          nonfinal_results;
    int          toolong_results;

    int unsigned idle_mode     = IDLE_NONE;
    // Each increment asks the receiver for one long hold-off.
    int unsigned hold_requests = 0;
    int unsigned bytes_sent    = 0;
    int unsigned frames_sent   = 0;
    int unsigned cycle_count   = 0;
    // The stimulus side's own copy of the length limit, used to shape frames.
    logic [31:0] max_len_setting = wsfd_pkg::MAX_LEN_RESET;

    always #HALF_PERIOD i_clk = ~i_clk;

    websocket_frame_decoder #(
        .LENGTH_COUNTER_BITS(LENGTH_COUNTER_BITS)
    ) DUT (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_max_payload_length_we(i_max_payload_length_we),
        .i_max_payload_length   (i_max_payload_length),
        .i_in_valid             (i_in_valid),
        .o_in_stall             (o_in_stall),
        .i_stream_byte          (i_stream_byte),
        .o_out_valid            (o_out_valid),
        .i_out_stall            (i_out_stall),
        .o_kind                 (o_kind),
        .o_payload_byte         (o_payload_byte),
        .o_frame_opcode         (o_frame_opcode),
        .o_last_byte            (o_last_byte)
    );

    websocket_frame_decoder_checker #(
        .LENGTH_COUNTER_BITS(LENGTH_COUNTER_BITS)
    ) frame_check (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_max_payload_length_we(i_max_payload_length_we),
        .i_max_payload_length   (i_max_payload_length),
        .i_in_valid             (i_in_valid),
        .i_in_stall             (o_in_stall),
        .i_stream_byte          (i_stream_byte),
        .i_out_valid            (o_out_valid),
        .i_out_stall            (i_out_stall),
        .i_kind                 (o_kind),
        .i_payload_byte         (o_payload_byte),
        .i_frame_opcode         (o_frame_opcode),
        .i_last_byte            (o_last_byte),
        .o_mismatches           (mismatches),
        .o_pending              (pending),
        .o_data_results         (data_results),
        .o_empty_results        (empty_results),
        .o_nonfinal_results     (nonfinal_results),
        .o_toolong_results      (toolong_results)
    );

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("websocket_frame_decoder_tb: errors");
            $finish;
        end
    end

    // About one idle stretch in twenty is long.
    function automatic int unsigned idle_length();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
    endfunction

    function automatic int unsigned sender_gap();
        case (idle_mode)
            IDLE_NONE:  return 0;
            IDLE_LIGHT: return ($urandom_range(0, 99) < 30) ? idle_length() : 0;
            default:    return ($urandom_range(0, 99) < 60) ? idle_length() : 0;
        endcase
    endfunction

    // Offers one byte, possibly after a gap, and holds it until it is taken.
    // Entered and left at a falling edge, so valid is assigned once per step.
    task automatic send_byte(input logic [7:0] value);
        int unsigned gap;
        gap = sender_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_stream_byte <= value;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    // One frame with random header bits, mask and key. Non-final frames stop after
    // two bytes and too-long frames after the length, since the decoder drops back
    // to a new header there. Other lengths stay small, sometimes hit the limit
    // exactly, and are sometimes sent in a wider length form than they need.
    task automatic send_random_frame();
        int unsigned pick;
        int unsigned span;
        int unsigned min_form;
        int unsigned form;
        logic        masked;
        logic [7:0]  head;
        logic [63:0] length;
        head   = 8'($urandom);
        masked = 1'($urandom_range(0, 1));
        pick   = $urandom_range(0, 99);
        frames_sent++;
        if (pick < 8) begin
            send_byte({1'b0, head[6:0]});
            send_byte(8'($urandom));
            return;
        end
        send_byte({1'b1, head[6:0]});
        if (pick < 18) begin
            length = {32'($urandom), 32'($urandom)};
            if (length <= {32'd0, max_len_setting}) begin
                length = {32'd0, max_len_setting} + 64'd1;
            end
        end else if (pick < 30 || max_len_setting == 0) begin
            length = 64'd0;
        end else if (pick < 38 && max_len_setting <= 400) begin
            length = {32'd0, max_len_setting};
        end else begin
            span = (pick < 90) ? 24 : 300;
            if (span > max_len_setting) begin
                span = max_len_setting;
            end
            length = 64'($urandom_range(1, span));
        end
        min_form = (length <= 125) ? 0 : (length <= 65535) ? 1 : 2;
        form     = ($urandom_range(0, 3) == 0) ? $urandom_range(min_form, 2) : min_form;
        case (form)
            0: send_byte({masked, length[6:0]});
            1: begin
                send_byte({masked, wsfd_pkg::LEN_CODE_EXT16});
                send_byte(length[15:8]);
                send_byte(length[7:0]);
            end
            default: begin
                send_byte({masked, wsfd_pkg::LEN_CODE_EXT64});
                for (int i = 7; i >= 0; i--) begin
                    send_byte(length[8 * i +: 8]);
                end
            end
        endcase
        if (pick < 18) begin
            return;
        end
        if (masked) begin
            repeat (4) send_byte(8'($urandom));
        end
        repeat (length[31:0]) send_byte(8'($urandom));
    endtask

    task automatic run_frames(input int unsigned budget);
        int unsigned start;
        start = bytes_sent;
        while (bytes_sent - start < budget) send_random_frame();
    endtask

    // Stops offering bytes and waits until every due result has come out and
    // the decoder has had time to finish any byte that gives no result.
    task automatic settle_idle();
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_length_limit(input logic [31:0] value);
        settle_idle();
        i_max_payload_length_we <= 1'b1;
        i_max_payload_length    <= value;
        @(negedge i_clk);
        i_max_payload_length_we <= 1'b0;
        max_len_setting = value;
    endtask

    // Receiver: random stall bursts, none at all in quiet stretches, and a long
    // hold-off whenever one is asked for, so the decoder's skid register fills
    // and it has to stall its own input while bytes keep coming.
    initial begin : result_stall
        int unsigned holds_done;
        int unsigned stall_cycles;
        logic        stall_value;
        holds_done  = 0;
        i_out_stall = 1'b0;
        @(negedge i_clk);
        forever begin
            if (holds_done < hold_requests) begin
                holds_done++;
                stall_value  = 1'b1;
                stall_cycles = HOLD_CYCLES;
            end else if (idle_mode == IDLE_NONE) begin
                stall_value  = 1'b0;
                stall_cycles = 1;
            end else begin
                stall_value  = ($urandom_range(0, 99) < ((idle_mode == IDLE_LIGHT) ? 25 : 50));
                stall_cycles = idle_length();
            end
            i_out_stall <= stall_value;
            repeat (stall_cycles) @(negedge i_clk);
        end
    end

    initial begin : stimulus
        i_rst_n                 = 1'b0;
        i_in_valid              = 1'b0;
        i_stream_byte           = 8'h00;
        i_max_payload_length_we = 1'b0;
        i_max_payload_length    = 32'd0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames under the limit that reset leaves in place.
        idle_mode = IDLE_LIGHT;
        foreach (DIRECTED_STREAM[i]) begin
            send_byte(DIRECTED_STREAM[i]);
        end
        run_frames(300);

        // Largest limit: only lengths beyond what the counter holds are refused.
        // No idling here, and one long receiver hold-off.
        set_length_limit(32'hFFFF_FFFF);
        idle_mode = IDLE_NONE;
        hold_requests++;
        run_frames(300);

        // Zero limit: only empty frames pass, under heavy idling.
        set_length_limit(32'd0);
        idle_mode = IDLE_HEAVY;
        run_frames(120);

        // Mid-size limit with frames right at it and some above it, plus a second hold-off.
        set_length_limit(32'd300);
        idle_mode = IDLE_LIGHT;
        hold_requests++;
        run_frames(330);

        // Noise: random bytes break the framing. A small limit bounds any payload
        // the noise may open, so a run of zero bytes always ends up alternating
        // between the two first header states; the three bytes after it bring
        // both cases back to the start of a frame (a one-byte final frame on one
        // path, two non-final errors on the other).
        set_length_limit(32'd20);
        idle_mode = IDLE_HEAVY;
        repeat (4) begin
            repeat (2) send_random_frame();
            repeat (24) send_byte(8'($urandom));
            repeat (max_len_setting + 16) send_byte(8'h00);
            send_byte(8'h80);
            send_byte(8'h01);
            send_byte(8'($urandom));
        end

        // Smallest nonzero limit.
        set_length_limit(32'd1);
        idle_mode = IDLE_LIGHT;
        run_frames(120);

        settle_idle();
        $display("Covered %0d stream bytes (%0d random frames plus directed and noise bytes)%s",
                 bytes_sent, frames_sent, " under length limits 0 to 4294967295.");
        $display("Checked %0d payload bytes, %0d empty frames, %0d non-final and %0d too-long.",
                 data_results, empty_results, nonfinal_results, toolong_results);
        if (mismatches == 0 && pending == 0) begin
            $display("websocket_frame_decoder_tb: clean");
        end else begin
            $display("websocket_frame_decoder_tb: errors");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+hdl
hdl/wsfd_pkg.sv
hdl/wsfd_parser.sv
hdl/websocket_frame_decoder.sv
test/websocket_frame_decoder_checker.sv
test/websocket_frame_decoder_tb.sv
